FILE: rtl/stack_machine_execute_unit_defines.svh
// Assertion macros shared by the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SMEU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define SMEU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Opcodes, status codes, defaults and control types of the execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

	localparam int MEMORY_WORDS_DEF       = 256;
	localparam int DATA_STACK_DEPTH_DEF   = 64;
	localparam int RETURN_STACK_DEPTH_DEF = 16;
	localparam int PC_BITS_DEF            = 16;

	localparam logic [3:0] OP_PUSH  = 4'd0;
	localparam logic [3:0] OP_POP   = 4'd1;
	localparam logic [3:0] OP_ADD   = 4'd2;
	localparam logic [3:0] OP_SUB   = 4'd3;
	localparam logic [3:0] OP_MUL   = 4'd4;
	localparam logic [3:0] OP_DIV   = 4'd5;
	localparam logic [3:0] OP_LOAD  = 4'd6;
	localparam logic [3:0] OP_STORE = 4'd7;
	localparam logic [3:0] OP_JUMP  = 4'd8;
	localparam logic [3:0] OP_JIF   = 4'd9;
	localparam logic [3:0] OP_CALL  = 4'd10;
	localparam logic [3:0] OP_RET   = 4'd11;
	localparam logic [3:0] OP_HALT  = 4'd12;
	localparam logic [3:0] OP_DEBUG = 4'd13;

	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_UNDER   = 4'd1;
	localparam logic [3:0] ST_OVER    = 4'd2;
	localparam logic [3:0] ST_DIVZERO = 4'd3;
	localparam logic [3:0] ST_RUNDER  = 4'd4;
	localparam logic [3:0] ST_ROVER   = 4'd5;
	localparam logic [3:0] ST_BADADDR = 4'd6;
	localparam logic [3:0] ST_BADTGT  = 4'd7;
	localparam logic [3:0] ST_UNKNOWN = 4'd8;
	localparam logic [3:0] ST_NOTRUN  = 4'd9;

	typedef struct packed {
		logic load;
		logic read;
		logic div_start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic need_div;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/smeu_div.sv
// ----------------------------------------------------------------------------
// smeu_div
// Radix-2 restoring signed divider, 32 bits, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module smeu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] mb_q;
	logic [32:0] shifted;
	logic [32:0] trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31] ^ divisor[31];
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			mb_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
			rem_q <= 32'd0;
		end else if (busy_q) begin
			if (shifted >= {1'b0, mb_q}) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

FILE: rtl/smeu_ctrl.sv
// ----------------------------------------------------------------------------
// smeu_ctrl
// Sequencer that steps one instruction through read and execute, plus divide when needed.
// ----------------------------------------------------------------------------
module smeu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  smeu_pkg::sts_t      sts,
	output smeu_pkg::cmd_t      cmd
);
	import smeu_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;
	localparam logic [1:0] S_DIV  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE) && !sts.clearing;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DIV: begin
				if (!sts.div_busy && sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/smeu_dp.sv
// ----------------------------------------------------------------------------
// smeu_dp
// Stacks, data memory, machine registers and the result register.
// ----------------------------------------------------------------------------
module smeu_dp #(
	parameter int MEMORY_WORDS       = smeu_pkg::MEMORY_WORDS_DEF,
	parameter int DATA_STACK_DEPTH   = smeu_pkg::DATA_STACK_DEPTH_DEF,
	parameter int RETURN_STACK_DEPTH = smeu_pkg::RETURN_STACK_DEPTH_DEF,
	parameter int PC_BITS            = smeu_pkg::PC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smeu_pkg::cmd_t     cmd,
	output smeu_pkg::sts_t     sts,
	input  logic [3:0]         action,
	input  logic signed [31:0] operand,
	input  logic               begin_program,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        next_pc,
	output logic [3:0]         status,
	output logic               halted,
	output logic signed [31:0] top_value,
	output logic [6:0]         stack_depth
);
	import smeu_pkg::*;

	localparam int MAW = $clog2(MEMORY_WORDS);
	localparam int DAW = $clog2(DATA_STACK_DEPTH);
	localparam int DCW = $clog2(DATA_STACK_DEPTH + 1);
	localparam int RAW = $clog2(RETURN_STACK_DEPTH);
	localparam int RCW = $clog2(RETURN_STACK_DEPTH + 1);

	logic [31:0]        ds_mem [DATA_STACK_DEPTH];
	logic [31:0]        dm_mem [MEMORY_WORDS];
	logic [PC_BITS-1:0] rs_mem [RETURN_STACK_DEPTH];

	logic [3:0]         op_q;
	logic [31:0]        opnd_q;
	logic               beg_q;
	logic [DCW-1:0]     cnt_q;
	logic [31:0]        tos_q;
	logic [RCW-1:0]     rc_q;
	logic [PC_BITS-1:0] pc_q;
	logic               run_q;
	logic [31:0]        ds_rd_q;
	logic [31:0]        dm_rd_q;
	logic [PC_BITS-1:0] rs_rd_q;
	logic               clr_busy_q;
	logic [MAW-1:0]     clr_q;
	logic               out_valid_q;

	logic [3:0]         st;
	logic [PC_BITS-1:0] npc;
	logic               ds_we;
	logic [DAW-1:0]     ds_wa;
	logic [31:0]        ds_wd;
	logic [DCW-1:0]     cnt_n;
	logic [31:0]        tos_n;
	logic               dm_we;
	logic               rs_we;
	logic [RCW-1:0]     rc_n;
	logic               halt;
	logic               addr_ok;
	logic               tgt_ok;
	logic [31:0]        arith;
	logic [31:0]        div_q;
	logic               div_busy;
	logic [DCW-1:0]     fin_cnt;
	logic [31:0]        fin_tos;
	logic [31:0]        fin_pc;
	logic [31:0]        fin_cnt_w;

	smeu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (ds_rd_q),
		.divisor  (tos_q),
		.busy     (div_busy),
		.quotient (div_q)
	);

	assign addr_ok = opnd_q < 32'(MEMORY_WORDS);
	assign tgt_ok  = !opnd_q[31] && ((opnd_q >> PC_BITS) == 32'd0);

	always_comb begin
		case (op_q)
			OP_ADD:  arith = ds_rd_q + tos_q;
			OP_SUB:  arith = ds_rd_q - tos_q;
			OP_MUL:  arith = ds_rd_q * tos_q;
			default: arith = div_q;
		endcase
	end

	always_comb begin
		st    = ST_OK;
		npc   = pc_q + 1'b1;
		ds_we = 1'b0;
		ds_wa = cnt_q[DAW-1:0];
		ds_wd = opnd_q;
		cnt_n = cnt_q;
		tos_n = tos_q;
		dm_we = 1'b0;
		rs_we = 1'b0;
		rc_n  = rc_q;
		halt  = 1'b0;
		if (!run_q) begin
			st = ST_NOTRUN;
		end else begin
			case (op_q)
				OP_PUSH, OP_LOAD: begin
					if (cnt_q == DCW'(DATA_STACK_DEPTH)) begin
						st = ST_OVER;
					end else if (op_q == OP_LOAD && !addr_ok) begin
						st = ST_BADADDR;
					end else begin
						ds_we = 1'b1;
						ds_wd = (op_q == OP_PUSH) ? opnd_q : dm_rd_q;
						tos_n = ds_wd;
						cnt_n = cnt_q + 1'b1;
					end
				end
				OP_POP: begin
					if (cnt_q == '0) begin
						st = ST_UNDER;
					end else begin
						cnt_n = cnt_q - 1'b1;
						tos_n = ds_rd_q;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (cnt_q < DCW'(2)) begin
						st = ST_UNDER;
					end else if (op_q == OP_DIV && tos_q == 32'd0) begin
						st = ST_DIVZERO;
					end else begin
						ds_we = 1'b1;
						ds_wa = DAW'(cnt_q - DCW'(2));
						ds_wd = arith;
						tos_n = arith;
						cnt_n = cnt_q - 1'b1;
					end
				end
				OP_STORE: begin
					if (cnt_q == '0) begin
						st = ST_UNDER;
					end else if (!addr_ok) begin
						st = ST_BADADDR;
					end else begin
						dm_we = 1'b1;
						cnt_n = cnt_q - 1'b1;
						tos_n = ds_rd_q;
					end
				end
				OP_JUMP: begin
					if (!tgt_ok) begin
						st = ST_BADTGT;
					end else begin
						npc = opnd_q[PC_BITS-1:0];
					end
				end
				OP_JIF: begin
					if (cnt_q == '0) begin
						st = ST_UNDER;
					end else if (tos_q != 32'd0 && !tgt_ok) begin
						st = ST_BADTGT;
					end else begin
						if (tos_q != 32'd0) begin
							npc = opnd_q[PC_BITS-1:0];
						end
						cnt_n = cnt_q - 1'b1;
						tos_n = ds_rd_q;
					end
				end
				OP_CALL: begin
					if (rc_q == RCW'(RETURN_STACK_DEPTH)) begin
						st = ST_ROVER;
					end else if (!tgt_ok) begin
						st = ST_BADTGT;
					end else begin
						rs_we = 1'b1;
						rc_n  = rc_q + 1'b1;
						npc   = opnd_q[PC_BITS-1:0];
					end
				end
				OP_RET: begin
					if (rc_q == '0) begin
						st = ST_RUNDER;
					end else begin
						rc_n = rc_q - 1'b1;
						npc  = rs_rd_q + 1'b1;
					end
				end
				OP_HALT: begin
					halt = 1'b1;
				end
				OP_DEBUG: begin
				end
				default: begin
					st = ST_UNKNOWN;
				end
			endcase
		end
	end

	assign fin_cnt   = (st == ST_OK) ? cnt_n : cnt_q;
	assign fin_tos   = (st == ST_OK) ? tos_n : tos_q;
	assign fin_pc    = 32'((st == ST_OK) ? npc : pc_q);
	assign fin_cnt_w = 32'(fin_cnt);

	assign sts.clearing = clr_busy_q;
	assign sts.need_div = run_q && op_q == OP_DIV && cnt_q >= DCW'(2) && tos_q != 32'd0;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rc_q        <= '0;
			pc_q        <= '0;
			run_q       <= 1'b1;
			clr_busy_q  <= 1'b1;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == MAW'(MEMORY_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cmd.read && beg_q) begin
				pc_q  <= '0;
				rc_q  <= '0;
				run_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (st == ST_OK) begin
					pc_q  <= npc;
					cnt_q <= cnt_n;
					rc_q  <= rc_n;
					if (halt) begin
						run_q <= 1'b0;
					end
				end else begin
					run_q <= 1'b0;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= action;
			opnd_q <= operand;
			beg_q  <= begin_program;
		end
		if (cmd.read) begin
			ds_rd_q <= ds_mem[DAW'(cnt_q - DCW'(2))];
			dm_rd_q <= dm_mem[opnd_q[MAW-1:0]];
			rs_rd_q <= rs_mem[RAW'(rc_q - 1'b1)];
		end
		if (cmd.commit && st == ST_OK) begin
			tos_q <= tos_n;
			if (ds_we) begin
				ds_mem[ds_wa] <= ds_wd;
			end
			if (rs_we) begin
				rs_mem[rc_q[RAW-1:0]] <= pc_q;
			end
		end
		if (clr_busy_q) begin
			dm_mem[clr_q] <= 32'd0;
		end else if (cmd.commit && st == ST_OK && dm_we) begin
			dm_mem[opnd_q[MAW-1:0]] <= tos_q;
		end
		if (cmd.commit) begin
			next_pc     <= fin_pc[15:0];
			status      <= st;
			halted      <= !(run_q && st == ST_OK && !halt);
			top_value   <= (fin_cnt == '0) ? 32'sd0 : $signed(fin_tos);
			stack_depth <= fin_cnt_w[6:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/stack_machine_execute_unit.sv
// Each instruction passes the sequencer's read and execute states, plus the divide
// state for a divide, before its result is registered; a new instruction is taken only
// in idle, so the 32-step radix-2 divider and a full output hold back the next input.
// Reset: pc, stack counts cleared, machine running; a clearing pass over all
// MEMORY_WORDS words zeroes data memory, during which no input is taken.
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack machine instruction per input transaction.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_unit_defines.svh"

module stack_machine_execute_unit #(
	parameter int MEMORY_WORDS       = smeu_pkg::MEMORY_WORDS_DEF,
	parameter int DATA_STACK_DEPTH   = smeu_pkg::DATA_STACK_DEPTH_DEF,
	parameter int RETURN_STACK_DEPTH = smeu_pkg::RETURN_STACK_DEPTH_DEF,
	parameter int PC_BITS            = smeu_pkg::PC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         action,
	input  logic signed [31:0] operand,
	input  logic               begin_program,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        next_pc,
	output logic [3:0]         status,
	output logic               halted,
	output logic signed [31:0] top_value,
	output logic [6:0]         stack_depth
);
	import smeu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	smeu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smeu_dp #(
		.MEMORY_WORDS       (MEMORY_WORDS),
		.DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
		.RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
		.PC_BITS            (PC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.operand       (operand),
		.begin_program (begin_program),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_pc       (next_pc),
		.status        (status),
		.halted        (halted),
		.top_value     (top_value),
		.stack_depth   (stack_depth)
	);

	`SMEU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`SMEU_ASSERT_NOW(a_fault_halts, out_valid && status != ST_OK, halted, "fault did not halt")
	`SMEU_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid || out_ready, "result overwritten")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// A directed table of instructions, followed by random programs, is driven
// through the input channel with random gaps. Every result is compared field
// by field against a behavioral model of the machine.
// ----------------------------------------------------------------------------
module tb;
	import smeu_pkg::*;

	localparam int MEM_WORDS = MEMORY_WORDS_DEF;
	localparam int DS_DEPTH  = DATA_STACK_DEPTH_DEF;
	localparam int RS_DEPTH  = RETURN_STACK_DEPTH_DEF;
	localparam int WATCHDOG  = 5000;
	localparam int N_ITEMS   = 1050;

	typedef struct {
		logic [15:0] pc;
		logic [3:0]  st;
		logic        hlt;
		logic [31:0] top;
		logic [6:0]  depth;
	} machine_state_t;

	typedef struct {
		logic [3:0]  act;
		logic [31:0] opnd;
		logic        bgn;
		logic        known;
		logic [3:0]  st;
		logic [6:0]  depth;
	} instr_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] action = '0;
	logic signed [31:0] operand = '0;
	logic begin_program = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] next_pc;
	logic [3:0] status;
	logic halted;
	logic signed [31:0] top_value;
	logic [6:0] stack_depth;

	logic [31:0] m_dstack [DS_DEPTH];
	logic [31:0] m_mem [MEM_WORDS];
	logic [15:0] m_rstack [RS_DEPTH];
	int unsigned m_dcount;
	int unsigned m_rcount;
	logic [15:0] m_pc;
	logic m_running;

	machine_state_t expected_results[$];
	instr_row_t directed[$];
	bit failed = 1'b0;
	int idle_cycles = 0;
	int n_sent = 0;
	int unsigned in_gap = 0;

	stack_machine_execute_unit i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic machine_state_t execute_instr(logic [3:0] act, logic [31:0] opnd,
			logic bgn);
		machine_state_t r;
		logic [3:0] st;
		logic [15:0] npc;
		logic [31:0] a, b, v;
		int unsigned n;
		st = ST_OK;
		npc = m_pc + 16'd1;
		n = m_dcount;
		if (bgn) begin
			m_pc = '0;
			m_rcount = 0;
			m_running = 1'b1;
			npc = 16'd1;
		end
		if (!m_running) begin
			st = ST_NOTRUN;
		end else begin
			case (act)
				OP_PUSH, OP_LOAD: begin
					if (n >= DS_DEPTH) st = ST_OVER;
					else if (act == OP_LOAD && opnd >= MEM_WORDS) st = ST_BADADDR;
					else begin
						m_dstack[n] = (act == OP_PUSH) ? opnd : m_mem[opnd[7:0]];
						m_dcount = n + 1;
					end
				end
				OP_POP: begin
					if (n == 0) st = ST_UNDER;
					else m_dcount = n - 1;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (n < 2) st = ST_UNDER;
					else begin
						a = m_dstack[n-2];
						b = m_dstack[n-1];
						case (act)
							OP_ADD: v = a + b;
							OP_SUB: v = a - b;
							OP_MUL: v = a * b;
							default: begin
								if (b == 0) st = ST_DIVZERO;
								else v = div_toward_zero(a, b);
							end
						endcase
						if (st == ST_OK) begin
							m_dstack[n-2] = v;
							m_dcount = n - 1;
						end
					end
				end
				OP_STORE: begin
					if (n == 0) st = ST_UNDER;
					else if (opnd >= MEM_WORDS) st = ST_BADADDR;
					else begin
						m_mem[opnd[7:0]] = m_dstack[n-1];
						m_dcount = n - 1;
					end
				end
				OP_JUMP: begin
					if (opnd > 32'hFFFF) st = ST_BADTGT;
					else npc = opnd[15:0];
				end
				OP_JIF: begin
					if (n == 0) st = ST_UNDER;
					else if (m_dstack[n-1] != 0 && opnd > 32'hFFFF) st = ST_BADTGT;
					else begin
						if (m_dstack[n-1] != 0) npc = opnd[15:0];
						m_dcount = n - 1;
					end
				end
				OP_CALL: begin
					if (m_rcount >= RS_DEPTH) st = ST_ROVER;
					else if (opnd > 32'hFFFF) st = ST_BADTGT;
					else begin
						m_rstack[m_rcount] = m_pc;
						m_rcount++;
						npc = opnd[15:0];
					end
				end
				OP_RET: begin
					if (m_rcount == 0) st = ST_RUNDER;
					else begin
						m_rcount--;
						npc = m_rstack[m_rcount] + 16'd1;
					end
				end
				OP_HALT: m_running = 1'b0;
				OP_DEBUG: ;
				default: st = ST_UNKNOWN;
			endcase
			if (st != ST_OK) m_running = 1'b0;
			else m_pc = npc;
		end
		r.pc = m_pc;
		r.st = st;
		r.hlt = !m_running;
		r.depth = m_dcount[6:0];
		r.top = (m_dcount > 0) ? m_dstack[m_dcount-1] : '0;
		return r;
	endfunction

	task automatic send_instr(logic [3:0] act, logic [31:0] opnd, logic bgn);
		repeat (in_gap) @(posedge clk);
		in_valid <= 1'b1;
		action <= act;
		operand <= opnd;
		begin_program <= bgn;
		expected_results = {expected_results, execute_instr(act, opnd, bgn)};
		n_sent++;
		do @(posedge clk); while (!in_ready);
		in_gap = $urandom_range(0, 8);
		if (in_gap > 0) in_valid <= 1'b0;
	endtask

	function automatic void add_row(logic [3:0] act, logic [31:0] opnd, logic bgn,
			logic known = 1'b0, logic [3:0] st = ST_OK, logic [6:0] depth = '0);
		instr_row_t r;
		r.act = act;
		r.opnd = opnd;
		r.bgn = bgn;
		r.known = known;
		r.st = st;
		r.depth = depth;
		directed = {directed, r};
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] random_target();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h0001_0000;
			2: return 32'h0000_FFFF;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic logic [31:0] random_addr();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return MEM_WORDS;
			default: return $urandom_range(0, MEM_WORDS - 1);
		endcase
	endfunction

	task automatic random_program(int len);
		logic [3:0] act;
		logic [31:0] opnd;
		logic bgn;
		bgn = 1'b1;
		for (int i = 0; i < len; i++) begin
			act = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 3) == 0) act = OP_PUSH;
			if (act == OP_HALT && $urandom_range(0, 3) != 0) act = OP_DEBUG;
			if (act >= 4'd14 && $urandom_range(0, 3) != 0) act = OP_ADD;
			if (m_dcount > 48 && act == OP_PUSH && $urandom_range(0, 1)) act = OP_POP;
			case (act)
				OP_LOAD, OP_STORE: opnd = random_addr();
				OP_JUMP, OP_JIF, OP_CALL: opnd = random_target();
				default: opnd = random_value();
			endcase
			if (!bgn && $urandom_range(0, 60) == 0) bgn = 1'b1;
			send_instr(act, opnd, bgn);
			bgn = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : sink
		int unsigned gap;
		forever begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		machine_state_t e;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transaction pc=%0d status=%0d", $time, next_pc,
					status);
				failed = 1'b1;
			end else begin
				e = expected_results.pop_front();
				if (next_pc !== e.pc || status !== e.st || halted !== e.hlt ||
						top_value !== e.top || stack_depth !== e.depth) begin
					$display("%0t: expected pc=%0d st=%0d h=%0d top=%h d=%0d, ",
						$time, e.pc, e.st, e.hlt, e.top, e.depth,
						"actual pc=%0d st=%0d h=%0d top=%h d=%0d",
						next_pc, status, halted, top_value, stack_depth);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		instr_row_t r;
		m_dcount = 0;
		m_rcount = 0;
		m_pc = '0;
		m_running = 1'b1;
		foreach (m_mem[i]) m_mem[i] = '0;

		add_row(OP_POP, 0, 1'b0, 1'b1, ST_UNDER, 7'd0);
		add_row(OP_DEBUG, 0, 1'b0, 1'b1, ST_NOTRUN, 7'd0);
		add_row(OP_RET, 0, 1'b1, 1'b1, ST_RUNDER, 7'd0);
		add_row(OP_LOAD, MEM_WORDS - 1, 1'b1, 1'b1, ST_OK, 7'd1);
		add_row(OP_PUSH, 32'h8000_0000, 1'b0);
		add_row(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
		add_row(OP_DIV, 0, 1'b0);
		add_row(OP_PUSH, 0, 1'b0);
		add_row(OP_DIV, 0, 1'b0, 1'b1, ST_DIVZERO, 7'd3);
		add_row(OP_PUSH, 32'h7FFF_FFFF, 1'b1);
		add_row(OP_PUSH, -7, 1'b0);
		add_row(OP_MUL, 0, 1'b0);
		add_row(OP_PUSH, 3, 1'b0);
		add_row(OP_SUB, 0, 1'b0);
		add_row(OP_ADD, 0, 1'b0);
		add_row(OP_STORE, MEM_WORDS, 1'b0, 1'b1, ST_BADADDR, 7'd3);
		add_row(OP_STORE, 0, 1'b1);
		add_row(OP_LOAD, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_BADADDR, 7'd2);
		add_row(OP_CALL, 32'h0000_FFFF, 1'b1);
		add_row(OP_CALL, 32'h0001_0000, 1'b0, 1'b1, ST_BADTGT, 7'd2);
		add_row(OP_JIF, 32'h8000_0000, 1'b1, 1'b1, ST_BADTGT, 7'd2);
		add_row(OP_JUMP, 32'h0000_1234, 1'b1);
		add_row(OP_RET, 0, 1'b0, 1'b1, ST_RUNDER, 7'd2);
		add_row(4'd14, 0, 1'b1, 1'b1, ST_UNKNOWN, 7'd2);
		add_row(4'd15, 0, 1'b1, 1'b1, ST_UNKNOWN, 7'd2);
		add_row(OP_HALT, 0, 1'b1, 1'b1, ST_OK, 7'd2);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			r = directed[i];
			send_instr(r.act, r.opnd, r.bgn);
			if (r.known && (expected_results[$].st !== r.st ||
					expected_results[$].depth !== r.depth)) begin
				$display("%0t: row %0d expected st=%0d d=%0d, model st=%0d d=%0d", $time, i,
					r.st, r.depth, expected_results[$].st, expected_results[$].depth);
				failed = 1'b1;
			end
		end

		// Stack and return stack overflow paths.
		send_instr(OP_DEBUG, 0, 1'b1);
		while (m_dcount < DS_DEPTH) send_instr(OP_PUSH, $urandom, 1'b0);
		send_instr(OP_PUSH, 1, 1'b0);
		send_instr(OP_LOAD, 0, 1'b1);
		for (int i = 0; i <= RS_DEPTH; i++) send_instr(OP_CALL, $urandom_range(0, 65535), i == 0);
		for (int i = 0; i <= RS_DEPTH; i++) send_instr(OP_RET, 0, i == 0);
		while (m_dcount > 0) send_instr(OP_POP, 0, 1'b1);

		while (n_sent < N_ITEMS) random_program($urandom_range(10, 60));
		if (in_gap == 0) in_valid <= 1'b0;

		while (expected_results.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
